@@ rtl/jac_pkg.sv @@
`timescale 1ns / 1ps

package jac_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int REG_BITS        = 12;
  localparam int RATIO_BITS      = 14;
  localparam int POS_BITS        = 12;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int CAL_SHIFT       = 10;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = CAL_SHIFT / STEPS_PER_STAGE;
  // input reg, front reg, divider stages, output reg
  localparam int PIPE_LATENCY    = DIV_STAGES + 3;

  localparam logic [POS_BITS-1:0] CAL_MID = 12'd256;
  localparam logic [POS_BITS-1:0] CAL_TOP = 12'd512;

  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_MODE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLAMP_LOW   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLAMP_HIGH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REST_CENTER = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_BELOW = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_ABOVE = 3'd5;

  localparam logic [REG_BITS-1:0]   CLAMP_LOW_RST   = 12'd0;
  localparam logic [REG_BITS-1:0]   CLAMP_HIGH_RST  = 12'd4095;
  localparam logic [REG_BITS-1:0]   REST_CENTER_RST = 12'd2048;
  localparam logic [RATIO_BITS-1:0] RATIO_BELOW_RST = 14'd8192;
  localparam logic [RATIO_BITS-1:0] RATIO_ABOVE_RST = 14'd8188;

  typedef struct packed {
    logic                  axis_mode;
    logic [REG_BITS-1:0]   clamp_low;
    logic [REG_BITS-1:0]   clamp_high;
    logic [REG_BITS-1:0]   rest_center;
    logic [RATIO_BITS-1:0] ratio_below;
    logic [RATIO_BITS-1:0] ratio_above;
  } jac_cfg_t;

  typedef struct packed {
    logic trigger;   // trigger axis, pass clamped sample
    logic fault;     // selected divisor is zero
    logic zero_out;  // clamped sample below clamp_low
    logic upper;     // sample above rest center
    logic ovf;       // quotient would reach 1024 or more
  } jac_flags_t;

  // one restoring division step, returns {quotient bit, new remainder}
  function automatic logic [RATIO_BITS:0] div_step(input logic [RATIO_BITS-1:0] rem,
                                                   input logic [RATIO_BITS-1:0] dvs);
    logic [RATIO_BITS:0] sh;
    logic [RATIO_BITS:0] diff;
    logic [RATIO_BITS:0] res;
    sh   = {rem, 1'b0};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      res = {1'b1, diff[RATIO_BITS-1:0]};
    end else begin
      res = {1'b0, sh[RATIO_BITS-1:0]};
    end
    return res;
  endfunction

endpackage

@@ rtl/joystick_axis_calibrate.sv @@
`timescale 1ns / 1ps

// joystick axis calibration, one raw adc sample in, one calibrated position out
//
// input: a transaction is taken at each rising edge with start high and busy low;
//   busy is only high while rst is asserted, so a sample can enter every cycle
// output: done pulses for one cycle with position and divide_fault; the receiver
//   has no way to stall, so each result must be captured in that cycle
// config: cfg_valid/cfg_ready write channel, cfg_index selects the register
//   (0 mode, 1 clamp low, 2 clamp high, 3 rest center, 4 ratio below,
//   5 ratio above), cfg_data is truncated to the register width; cfg_ready is
//   always high; write only while no sample is in flight
// pipeline: a sample passes the input reg, clamp/select stage, five divider
//   stages and output reg before it shows done
// throughput: one sample per cycle; the 10-bit quotient comes from a restoring
//   divider unrolled two steps per stage
// reset: synchronous, clears all stage valid bits and loads the default
//   calibration registers; samples in flight are dropped
module joystick_axis_calibrate import jac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic                     done,
  output logic [POS_BITS-1:0]      position,
  output logic                     divide_fault,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  jac_cfg_t cfg;

  // input register
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;

  // clamp/select stage to divider
  logic                   fr_valid;
  logic [SAMPLE_BITS-1:0] fr_num;
  logic [RATIO_BITS-1:0]  fr_dvs;
  jac_flags_t             fr_flags;
  logic [SAMPLE_BITS-1:0] fr_byp;

  // divider to output stage
  logic                   dv_valid;
  logic [CAL_SHIFT-1:0]   dv_quo;
  jac_flags_t             dv_flags;
  logic [SAMPLE_BITS-1:0] dv_byp;

  // fully pipelined, nothing holds the input off except reset
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // calibration registers, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mode   <= 1'b0;
      cfg.clamp_low   <= CLAMP_LOW_RST;
      cfg.clamp_high  <= CLAMP_HIGH_RST;
      cfg.rest_center <= REST_CENTER_RST;
      cfg.ratio_below <= RATIO_BELOW_RST;
      cfg.ratio_above <= RATIO_ABOVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AXIS_MODE:   cfg.axis_mode   <= cfg_data[0];
        REG_CLAMP_LOW:   cfg.clamp_low   <= cfg_data[REG_BITS-1:0];
        REG_CLAMP_HIGH:  cfg.clamp_high  <= cfg_data[REG_BITS-1:0];
        REG_REST_CENTER: cfg.rest_center <= cfg_data[REG_BITS-1:0];
        REG_RATIO_BELOW: cfg.ratio_below <= cfg_data[RATIO_BITS-1:0];
        REG_RATIO_ABOVE: cfg.ratio_above <= cfg_data[RATIO_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // capture the sample transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_sample <= sample;
  end

  // clamp, pick the segment and its divisor, flag the special cases
  jac_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .cfg       (cfg),
    .out_valid (fr_valid),
    .out_num   (fr_num),
    .out_dvs   (fr_dvs),
    .out_flags (fr_flags),
    .out_byp   (fr_byp)
  );

  // (offset << 10) / ratio, overflow detected up front
  jac_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_dvs    (fr_dvs),
    .in_flags  (fr_flags),
    .in_byp    (fr_byp),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_flags (dv_flags),
    .out_byp   (dv_byp)
  );

  // segment offset, saturation and the result register
  jac_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv_valid),
    .in_quo       (dv_quo),
    .in_flags     (dv_flags),
    .in_byp       (dv_byp),
    .done         (done),
    .position     (position),
    .divide_fault (divide_fault)
  );

endmodule

@@ rtl/jac_front.sv @@
`timescale 1ns / 1ps

module jac_front import jac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  jac_cfg_t               cfg,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_num,
  output logic [RATIO_BITS-1:0]  out_dvs,
  output jac_flags_t             out_flags,
  output logic [SAMPLE_BITS-1:0] out_byp
);

  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] hi;
  logic [SAMPLE_BITS-1:0] ctr;
  logic [SAMPLE_BITS-1:0] s_lo;
  logic [SAMPLE_BITS-1:0] s_cl;
  logic                   below;
  logic [RATIO_BITS-1:0]  dvs;
  logic [SAMPLE_BITS-1:0] num_next;
  logic [SAMPLE_BITS-1:0] byp_next;
  jac_flags_t             flags_next;

  assign lo  = SAMPLE_BITS'(cfg.clamp_low);
  assign hi  = SAMPLE_BITS'(cfg.clamp_high);
  assign ctr = SAMPLE_BITS'(cfg.rest_center);

  // low clamp first, high clamp last
  assign s_lo  = (in_sample < lo) ? lo : in_sample;
  assign s_cl  = (s_lo > hi) ? hi : s_lo;
  assign below = (s_cl <= ctr);
  assign dvs   = below ? cfg.ratio_below : cfg.ratio_above;

  assign num_next = below ? (s_cl - lo) : (s_cl - ctr);
  assign byp_next = (in_sample > hi) ? hi : in_sample;

  always_comb begin
    flags_next          = '0;
    flags_next.trigger  = cfg.axis_mode;
    flags_next.fault    = !cfg.axis_mode && (dvs == '0);
    flags_next.zero_out = below && (s_cl < lo);
    flags_next.upper    = !below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_num   <= num_next;
    out_dvs   <= dvs;
    out_flags <= flags_next;
    out_byp   <= byp_next;
  end

endmodule

@@ rtl/jac_div.sv @@
`timescale 1ns / 1ps

module jac_div import jac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_num,
  input  logic [RATIO_BITS-1:0]  in_dvs,
  input  jac_flags_t             in_flags,
  input  logic [SAMPLE_BITS-1:0] in_byp,
  output logic                   out_valid,
  output logic [CAL_SHIFT-1:0]   out_quo,
  output jac_flags_t             out_flags,
  output logic [SAMPLE_BITS-1:0] out_byp
);

  localparam int CW = (SAMPLE_BITS > RATIO_BITS) ? SAMPLE_BITS : RATIO_BITS;

  logic                   vld_q [DIV_STAGES];
  logic [RATIO_BITS-1:0]  rem_q [DIV_STAGES];
  logic [CAL_SHIFT-1:0]   quo_q [DIV_STAGES];
  logic [RATIO_BITS-1:0]  dvs_q [DIV_STAGES];
  jac_flags_t             flg_q [DIV_STAGES];
  logic [SAMPLE_BITS-1:0] byp_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
    logic                   v_i;
    logic [RATIO_BITS-1:0]  rem_i;
    logic [CAL_SHIFT-1:0]   quo_i;
    logic [RATIO_BITS-1:0]  dvs_i;
    jac_flags_t             flg_i;
    logic [SAMPLE_BITS-1:0] byp_i;
    logic [RATIO_BITS-1:0]  rem_c;
    logic [CAL_SHIFT-1:0]   quo_c;

    if (g == 0) begin : g_src
      // numerator at or above divisor means quotient of 1024 or more
      always_comb begin
        v_i       = in_valid;
        dvs_i     = in_dvs;
        byp_i     = in_byp;
        flg_i     = in_flags;
        flg_i.ovf = (CW'(in_num) >= CW'(in_dvs));
        rem_i     = RATIO_BITS'(in_num);
        quo_i     = '0;
      end
    end else begin : g_src
      assign v_i   = vld_q[g-1];
      assign rem_i = rem_q[g-1];
      assign quo_i = quo_q[g-1];
      assign dvs_i = dvs_q[g-1];
      assign flg_i = flg_q[g-1];
      assign byp_i = byp_q[g-1];
    end

    always_comb begin
      logic [RATIO_BITS:0]   st;
      logic [RATIO_BITS-1:0] r;
      logic [CAL_SHIFT-1:0]  q;
      r = rem_i;
      q = quo_i;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        st = div_step(r, dvs_i);
        r  = st[RATIO_BITS-1:0];
        q  = {q[CAL_SHIFT-2:0], st[RATIO_BITS]};
      end
      rem_c = r;
      quo_c = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[g] <= rem_c;
      quo_q[g] <= quo_c;
      dvs_q[g] <= dvs_i;
      flg_q[g] <= flg_i;
      byp_q[g] <= byp_i;
    end
  end

  assign out_valid = vld_q[DIV_STAGES-1];
  assign out_quo   = quo_q[DIV_STAGES-1];
  assign out_flags = flg_q[DIV_STAGES-1];
  assign out_byp   = byp_q[DIV_STAGES-1];

endmodule

@@ rtl/jac_back.sv @@
`timescale 1ns / 1ps

module jac_back import jac_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [CAL_SHIFT-1:0]   in_quo,
  input  jac_flags_t             in_flags,
  input  logic [SAMPLE_BITS-1:0] in_byp,
  output logic                   done,
  output logic [POS_BITS-1:0]    position,
  output logic                   divide_fault
);

  logic [CAL_SHIFT:0]  sum;
  logic [POS_BITS-1:0] stick;
  logic [POS_BITS-1:0] pos_next;

  assign sum = {1'b0, in_quo} + (in_flags.upper ? (CAL_SHIFT+1)'(CAL_MID) : '0);

  always_comb begin
    if (in_flags.ovf || (POS_BITS'(sum) > CAL_TOP)) begin
      stick = CAL_TOP;
    end else begin
      stick = POS_BITS'(sum);
    end
  end

  always_comb begin
    priority if (in_flags.trigger) begin
      pos_next = POS_BITS'(in_byp);
    end else if (in_flags.fault) begin
      pos_next = in_flags.upper ? CAL_TOP : CAL_MID;
    end else if (in_flags.zero_out) begin
      pos_next = '0;
    end else begin
      pos_next = stick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    position     <= pos_next;
    divide_fault <= in_flags.fault;
  end

endmodule

@@ rtl/jac_checker.sv @@
`timescale 1ns / 1ps

module jac_checker import jac_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [POS_BITS-1:0] position,
  input logic                divide_fault
);

  // every result comes from a sample taken a fixed latency earlier
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without a matching sample transaction");

  // a zero divisor reports the segment end
  a_fault_value: assert property (@(posedge clk) disable iff (rst)
    (done && divide_fault) |-> (position == CAL_MID || position == CAL_TOP))
    else $error("divide fault with a position other than a segment end");

  // the pipeline is empty right after reset
  a_reset_flush: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(rst))
    else $error("result right after reset");

endmodule

bind joystick_axis_calibrate jac_checker u_jac_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .position     (position),
  .divide_fault (divide_fault)
);

@@ dv/axis_cal_checker.sv @@
`timescale 1ns / 1ps

module axis_cal_checker import jac_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [REG_BITS-1:0]      sample,
  input  logic                     done,
  input  logic [POS_BITS-1:0]      position,
  input  logic                     divide_fault,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       mismatches,
  output int                       outstanding,
  output int                       results_seen,
  output int                       fault_cases,
  output int                       trigger_cases
);

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic                fault;
  } axis_result_t;

  jac_cfg_t     cal;
  axis_result_t expected_positions[$];
  axis_result_t want;

  function automatic axis_result_t calibrate_sample(input jac_cfg_t c,
                                                    input logic [REG_BITS-1:0] raw);
    logic [REG_BITS-1:0] s;
    logic [31:0]         q;
    axis_result_t        r;
    s       = raw;
    r.pos   = '0;
    r.fault = 1'b0;
    if (c.axis_mode) begin
      // trigger axis, upper clamp only
      r.pos = (s > c.clamp_high) ? c.clamp_high : s;
    end else begin
      // low clamp first, high clamp wins when the two cross
      if (s < c.clamp_low) s = c.clamp_low;
      if (s > c.clamp_high) s = c.clamp_high;
      if (s <= c.rest_center) begin
        if (c.ratio_below == '0) begin
          r.pos   = CAL_MID;
          r.fault = 1'b1;
        end else if (s < c.clamp_low) begin
          r.pos = '0;
        end else begin
          q     = (32'(s - c.clamp_low) << CAL_SHIFT) / 32'(c.ratio_below);
          r.pos = (q > 32'(CAL_TOP)) ? CAL_TOP : q[POS_BITS-1:0];
        end
      end else begin
        if (c.ratio_above == '0) begin
          r.pos   = CAL_TOP;
          r.fault = 1'b1;
        end else begin
          q     = 32'(CAL_MID) +
                  ((32'(s - c.rest_center) << CAL_SHIFT) / 32'(c.ratio_above));
          r.pos = (q > 32'(CAL_TOP)) ? CAL_TOP : q[POS_BITS-1:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cal.axis_mode   = 1'b0;
      cal.clamp_low   = CLAMP_LOW_RST;
      cal.clamp_high  = CLAMP_HIGH_RST;
      cal.rest_center = REST_CENTER_RST;
      cal.ratio_below = RATIO_BELOW_RST;
      cal.ratio_above = RATIO_ABOVE_RST;
      expected_positions.delete();
    end else begin
      if (done) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: result with nothing expected, position %0d fault %0b",
                   $time, position, divide_fault);
          mismatches++;
        end else begin
          want = expected_positions.pop_front();
          results_seen++;
          if (position !== want.pos) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.pos, position);
            mismatches++;
          end
          if (divide_fault !== want.fault) begin
            $display("%0t: divide_fault mismatch, expected %0b, actual %0b",
                     $time, want.fault, divide_fault);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        want = calibrate_sample(cal, sample);
        expected_positions.push_back(want);
        if (want.fault) fault_cases++;
        if (cal.axis_mode) trigger_cases++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AXIS_MODE:   cal.axis_mode   = cfg_data[0];
          REG_CLAMP_LOW:   cal.clamp_low   = cfg_data[REG_BITS-1:0];
          REG_CLAMP_HIGH:  cal.clamp_high  = cfg_data[REG_BITS-1:0];
          REG_REST_CENTER: cal.rest_center = cfg_data[REG_BITS-1:0];
          REG_RATIO_BELOW: cal.ratio_below = cfg_data[RATIO_BITS-1:0];
          REG_RATIO_ABOVE: cal.ratio_above = cfg_data[RATIO_BITS-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_positions.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import jac_pkg::*; ();

  localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
  // cycles to keep waiting on results before a drain gives up
  localparam int DRAIN_LIMIT = 64 * PIPE_LATENCY;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 130;
  // the last phases run with the sender never idling
  localparam int CALM_PHASES = 2;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     start     = 1'b0;
  logic [SAMPLE_W-1:0]      sample    = '0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                     busy;
  logic                     done;
  logic [POS_BITS-1:0]      position;
  logic                     divide_fault;
  logic                     cfg_ready;

  int mismatches;
  int outstanding;
  int results_seen;
  int fault_cases;
  int trigger_cases;
  int samples_sent;
  int settings_loaded;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  joystick_axis_calibrate u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .done         (done),
    .position     (position),
    .divide_fault (divide_fault),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // watches both channels, predicts each position and compares
  axis_cal_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample        (sample),
    .done          (done),
    .position      (position),
    .divide_fault  (divide_fault),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .fault_cases   (fault_cases),
    .trigger_cases (trigger_cases)
  );

  // write every calibration register back to back; junk above each
  // register's width checks that the block drops the upper data bits.
  // with touch_spare the two unused indexes get a write as well
  task automatic load_cal(input jac_cfg_t c, input bit touch_spare);
    logic [CFG_DATA_BITS-1:0] junk;
    logic [CFG_DATA_BITS-1:0] word;
    int last_idx;
    last_idx = touch_spare ? (1 << CFG_IDX_BITS) - 1 : int'(REG_RATIO_ABOVE);
    for (int i = 0; i <= last_idx; i++) begin
      junk = CFG_DATA_BITS'($urandom);
      case (CFG_IDX_BITS'(i))
        REG_AXIS_MODE:   word = {junk[CFG_DATA_BITS-1:1], c.axis_mode};
        REG_CLAMP_LOW:   word = {junk[CFG_DATA_BITS-1:REG_BITS], c.clamp_low};
        REG_CLAMP_HIGH:  word = {junk[CFG_DATA_BITS-1:REG_BITS], c.clamp_high};
        REG_REST_CENTER: word = {junk[CFG_DATA_BITS-1:REG_BITS], c.rest_center};
        REG_RATIO_BELOW: word = {junk[CFG_DATA_BITS-1:RATIO_BITS], c.ratio_below};
        REG_RATIO_ABOVE: word = {junk[CFG_DATA_BITS-1:RATIO_BITS], c.ratio_above};
        default:         word = junk;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data  <= word;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // one sample transaction, optionally preceded by an idle burst
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(13, 1)) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    samples_sent++;
  endtask

  // hold the sender off until every predicted position has come back, then
  // give the pipeline its full depth so a register write finds it empty
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  function automatic jac_cfg_t random_cal();
    jac_cfg_t c;
    int unsigned kind;
    kind          = $urandom_range(9);
    c.axis_mode   = 1'b0;
    c.clamp_low   = REG_BITS'($urandom);
    c.clamp_high  = REG_BITS'($urandom);
    c.rest_center = REG_BITS'($urandom);
    c.ratio_below = RATIO_BITS'($urandom);
    c.ratio_above = RATIO_BITS'($urandom);
    if (kind < 6) begin
      // sensible calibration: low below center below high, ratios as the
      // driver derives them, now and then nudged so a segment overshoots
      c.clamp_low   = REG_BITS'($urandom_range(1500));
      c.clamp_high  = REG_BITS'($urandom_range(4095, 2600));
      c.rest_center = REG_BITS'($urandom_range(c.clamp_high, c.clamp_low));
      c.ratio_below = RATIO_BITS'(4 * (int'(c.rest_center) - int'(c.clamp_low)));
      c.ratio_above = RATIO_BITS'(4 * (int'(c.clamp_high) - int'(c.rest_center)));
      if (kind == 5) begin
        c.ratio_below = c.ratio_below - RATIO_BITS'($urandom_range(40));
        c.ratio_above = c.ratio_above - RATIO_BITS'($urandom_range(40));
      end
    end else if (kind == 6) begin
      // tiny divisors, most positions saturate
      c.ratio_below = RATIO_BITS'($urandom_range(64));
      c.ratio_above = RATIO_BITS'($urandom_range(64));
    end else if (kind == 7) begin
      c.axis_mode = 1'b1;
    end else begin
      // raw register noise, clamps may cross, divisors may be zero
      c.axis_mode = 1'($urandom_range(3) == 0);
      if ($urandom_range(2) == 0) c.ratio_below = '0;
      if ($urandom_range(2) == 0) c.ratio_above = '0;
    end
    return c;
  endfunction

  // samples crowd around the clamps and the center where the segments turn
  function automatic logic [SAMPLE_W-1:0] pick_sample(input jac_cfg_t c);
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0, 1, 2, 3: s = SAMPLE_W'($urandom);
      4:          s = c.clamp_low + SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
      5:          s = c.clamp_high + SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
      6, 7:       s = c.rest_center + SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
      8:          s = ($urandom_range(1) == 0) ? '0 : '1;
      default:    s = c.rest_center + SAMPLE_W'($urandom_range(1));
    endcase
    return s;
  endfunction

  initial begin : stimulus
    jac_cfg_t c;
    int idle_pct;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration: rails, center and both sides of it
    send_sample(12'd0, 0);
    send_sample(12'd4095, 0);
    send_sample(12'd2048, 0);
    send_sample(12'd2049, 0);
    send_sample(12'd2047, 0);
    send_sample(12'd1, 0);
    settle();

    // both divisors zero, each segment reports its end with the fault flag
    c = '{1'b0, 12'd100, 12'd3900, 12'd2000, 14'd0, 14'd0};
    load_cal(c, 1'b0);
    send_sample(12'd2000, 0);
    send_sample(12'd3000, 0);
    send_sample(12'd50, 0);
    settle();

    // low clamp above high clamp, clamped sample sits under the low clamp
    c = '{1'b0, 12'd3000, 12'd1000, 12'd2000, 14'd4, 14'd4};
    load_cal(c, 1'b0);
    send_sample(12'd500, 0);
    send_sample(12'd4095, 0);
    settle();

    // unit divisors, quotients overshoot and saturate
    c = '{1'b0, 12'd0, 12'd4095, 12'd2048, 14'd1, 14'd1};
    load_cal(c, 1'b0);
    send_sample(12'd1, 0);
    send_sample(12'd2049, 0);
    send_sample(12'd4095, 0);
    settle();

    // trigger axis ignores the divisors and the low clamp
    c = '{1'b1, 12'd0, 12'd2000, 12'd2048, 14'd0, 14'd0};
    load_cal(c, 1'b0);
    send_sample(12'd0, 0);
    send_sample(12'd1999, 0);
    send_sample(12'd2000, 0);
    send_sample(12'd4095, 0);
    settle();

    // every clamp, center and ratio register at its top value, unused indexes written too
    c = '{1'b0, 12'd4095, 12'd4095, 12'd4095, 14'd16383, 14'd16383};
    load_cal(c, 1'b1);
    send_sample(12'd0, 0);
    send_sample(12'd4095, 0);
    settle();

    // every register at zero
    c = '{1'b0, 12'd0, 12'd0, 12'd0, 14'd0, 14'd0};
    load_cal(c, 1'b0);
    send_sample(12'd4095, 0);
    settle();

    // random calibrations; the sender idles in bursts except for stretches
    // picked to stay busy and the closing phases
    for (int p = 0; p < RAND_PHASES; p++) begin
      c = random_cal();
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      if (p >= RAND_PHASES - CALM_PHASES) idle_pct = 0;
      load_cal(c, p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_sample(c), idle_pct);
      end
      settle();
    end

    if (outstanding != 0) begin
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    end
    $display("covered %0d samples under %0d register settings, %0d results checked",
             samples_sent, settings_loaded + 1, results_seen);
    $display("%0d results hit a zero divisor, %0d came from trigger mode",
             fault_cases, trigger_cases);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
